FILE: hw/rtl/wah_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wah_pkg;

    localparam int SAMPLE_WIDTH     = 24;
    localparam int SINE_TABLE_BITS  = 10;
    localparam int COEFF_TABLE_BITS = 10;

    localparam int SINE_DEPTH  = 2 ** SINE_TABLE_BITS;
    localparam int COEFF_DEPTH = 2 ** COEFF_TABLE_BITS;

    localparam int PHASE_W = 32;
    localparam int STATE_W = 32;
    localparam int STEP_W  = 24;
    localparam int RATIO_W = 17;
    localparam int LFO_W   = 17;
    localparam int COEFF_W = 16;
    localparam int GAIN_W  = 16;
    localparam int CLAMP_W = 15;

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATIO  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATIO  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX    = 3'd5;

    localparam logic [GAIN_W-1:0]  DAMPING_RESET = 16'd16384;
    localparam logic [GAIN_W-1:0]  MIX_ONE       = 16'd32768;
    localparam logic [CLAMP_W-1:0] RATIO_MAX     = 15'd32112;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [STATE_W-1:0]      state_t;
    typedef logic signed [MUL_A_W-1:0]      mul_a_t;
    typedef logic signed [MUL_B_W-1:0]      mul_b_t;
    typedef logic signed [PROD_W-1:0]       prod_t;

    typedef logic [LFO_W-1:0]   lfo_rom_t [SINE_DEPTH];
    typedef logic [COEFF_W-1:0] coeff_rom_t [COEFF_DEPTH];

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // truncated taylor sine, angle in q0.32 turns, result in q30
    function automatic longint sine_q30(input longint unsigned ang);
        longint unsigned quad;
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p3;
        longint unsigned p5;
        longint unsigned p7;
        longint unsigned p9;
        longint          s;
        quad = ang >> 30;
        f    = ang & 64'h3FFF_FFFF;
        if (quad[0])
        begin
            f = Q30_ONE - f;
        end
        x  = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        p3 = (x * x2) >> 30;
        p5 = (p3 * x2) >> 30;
        p7 = (p5 * x2) >> 30;
        p9 = (p7 * x2) >> 30;
        s  = longint'(x) - longint'(p3 / 6) + longint'(p5 / 120)
             - longint'(p7 / 5040) + longint'(p9 / 362880);
        if (s > longint'(Q30_ONE))
        begin
            s = longint'(Q30_ONE);
        end
        if (s < 0)
        begin
            s = 0;
        end
        return quad[1] ? -s : s;
    endfunction

    function automatic lfo_rom_t build_lfo_rom();
        lfo_rom_t        rom;
        longint unsigned ang;
        longint          v;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            ang    = longint'(i) << (32 - SINE_TABLE_BITS);
            v      = (longint'(Q30_ONE) + sine_q30(ang) + 16384) >>> 15;
            rom[i] = LFO_W'(v);
        end
        return rom;
    endfunction

    function automatic coeff_rom_t build_coeff_rom();
        coeff_rom_t      rom;
        longint unsigned ang;
        longint          v;
        for (int i = 0; i < COEFF_DEPTH; i++)
        begin
            ang    = longint'(i) << (30 - COEFF_TABLE_BITS);
            v      = (sine_q30(ang) + 16384) >>> 15;
            rom[i] = COEFF_W'(v);
        end
        return rom;
    endfunction

    localparam lfo_rom_t   LFO_ROM   = build_lfo_rom();
    localparam coeff_rom_t COEFF_ROM = build_coeff_rom();

    // floor((v + 2^(s-1)) / 2^s)
    function automatic prod_t round_shift(input prod_t v, input int unsigned s);
        return (v + (prod_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic state_t sat_state(input prod_t v);
        state_t r;
        if ((v[PROD_W-1:STATE_W-1] == '0) || (v[PROD_W-1:STATE_W-1] == '1))
        begin
            r = v[STATE_W-1:0];
        end
        else
        begin
            r = v[PROD_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic sample_t sat_sample(input prod_t v);
        sample_t r;
        if ((v[PROD_W-1:SAMPLE_WIDTH-1] == '0) || (v[PROD_W-1:SAMPLE_WIDTH-1] == '1))
        begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            r = v[PROD_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                            : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wah_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wah_in_if;
    import wah_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wah_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wah_out_if;
    import wah_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wah_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module wah_mul (
    input  logic            clk,
    input  wah_pkg::mul_a_t op_a,
    input  wah_pkg::mul_b_t op_b,
    output wah_pkg::prod_t  prod
);
    import wah_pkg::*;

    prod_t prod_reg;
    prod_t prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/wah_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module wah_rom (
    input  logic                                  clk,
    input  logic [wah_pkg::SINE_TABLE_BITS-1:0]   lfo_idx,
    input  logic [wah_pkg::COEFF_TABLE_BITS-1:0]  coeff_idx,
    output logic [wah_pkg::LFO_W-1:0]             lfo_val,
    output logic [wah_pkg::COEFF_W-1:0]           coeff_val
);
    import wah_pkg::*;

    logic [LFO_W-1:0]   lfo_reg;
    logic [LFO_W-1:0]   lfo_next;
    logic [COEFF_W-1:0] coeff_reg;
    logic [COEFF_W-1:0] coeff_next;

    assign lfo_next   = LFO_ROM[lfo_idx];
    assign coeff_next = COEFF_ROM[coeff_idx];

    always_ff @(posedge clk)
    begin
        lfo_reg   <= lfo_next;
        coeff_reg <= coeff_next;
    end

    assign lfo_val   = lfo_reg;
    assign coeff_val = coeff_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lfo_swept_svf_bandpass_wah.sv
`timescale 1ns / 1ps
`default_nettype none

// Auto-wah: a sine LFO sweeps the centre of a state-variable band-pass filter and the
// band output is mixed with the dry sample. When enabled, a sample steps through the
// sequencer states; when bypassed it goes straight to the done state. No new sample is
// taken until the last result is in the output register. Every product goes through the
// single 36x18 multiplier under the sequencer. The result sits in an output register, so
// a stall on the output side only holds the block once that register is still full when
// the next result is ready. Write configuration only while the block is idle.
module lfo_swept_svf_bandpass_wah (
    input  logic                             clk,
    input  logic                             rst_n,
    wah_in_if.sink                           audio,
    wah_out_if.source                        result,
    input  logic                             cfg_wr_en,
    input  logic [wah_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wah_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import wah_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] ST_MUL_RATIO = 4'd1;
    localparam logic [ST_W-1:0] ST_RATIO     = 4'd2;
    localparam logic [ST_W-1:0] ST_COEFF     = 4'd3;
    localparam logic [ST_W-1:0] ST_MUL_LOW   = 4'd4;
    localparam logic [ST_W-1:0] ST_LOW       = 4'd5;
    localparam logic [ST_W-1:0] ST_HIGH      = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL_BAND  = 4'd7;
    localparam logic [ST_W-1:0] ST_BAND      = 4'd8;
    localparam logic [ST_W-1:0] ST_MIX1      = 4'd9;
    localparam logic [ST_W-1:0] ST_MIX2      = 4'd10;
    localparam logic [ST_W-1:0] ST_DONE      = 4'd11;

    logic [ST_W-1:0]    state_reg;
    logic [ST_W-1:0]    state_next;

    logic               enabled_reg;
    logic               enabled_next;
    logic [STEP_W-1:0]  phase_step_reg;
    logic [STEP_W-1:0]  phase_step_next;
    logic [RATIO_W-1:0] min_ratio_reg;
    logic [RATIO_W-1:0] min_ratio_next;
    logic [RATIO_W-1:0] max_ratio_reg;
    logic [RATIO_W-1:0] max_ratio_next;
    logic [GAIN_W-1:0]  damping_reg;
    logic [GAIN_W-1:0]  damping_next;
    logic [GAIN_W-1:0]  wet_mix_reg;
    logic [GAIN_W-1:0]  wet_mix_next;

    state_t             low_state_reg;
    state_t             low_state_next;
    state_t             band_state_reg;
    state_t             band_state_next;
    logic [PHASE_W-1:0] lfo_phase_reg;
    logic [PHASE_W-1:0] lfo_phase_next;

    sample_t            x_reg;
    sample_t            x_next;
    logic [CLAMP_W-1:0] ratio_reg;
    logic [CLAMP_W-1:0] ratio_next;
    mul_a_t             high_reg;
    mul_a_t             high_next;
    prod_t              acc_reg;
    prod_t              acc_next;
    sample_t            y_reg;
    sample_t            y_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    sample_t            out_data_reg;
    sample_t            out_data_next;

    mul_a_t             op_a;
    mul_b_t             op_b;
    prod_t              prod;
    logic [LFO_W-1:0]   lfo_val;
    logic [COEFF_W-1:0] coeff_val;

    logic               in_xfer;
    logic [GAIN_W-1:0]  mix_gain;
    logic [GAIN_W:0]    dry_gain;
    logic signed [RATIO_W:0] ratio_span;
    prod_t              ratio_full;
    prod_t              low_sum;
    prod_t              high_sum;
    prod_t              band_sum;
    prod_t              mix_sum;

    wah_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    wah_rom u_rom (
        .clk       (clk),
        .lfo_idx   (lfo_phase_reg[PHASE_W-1 -: SINE_TABLE_BITS]),
        .coeff_idx (ratio_reg[CLAMP_W-1 -: COEFF_TABLE_BITS]),
        .lfo_val   (lfo_val),
        .coeff_val (coeff_val)
    );

    assign audio.ready       = (state_reg == ST_IDLE);
    assign in_xfer           = audio.valid && audio.ready;
    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_data_reg;

    assign mix_gain   = (wet_mix_reg > MIX_ONE) ? MIX_ONE : wet_mix_reg;
    assign dry_gain   = {1'b0, MIX_ONE} - {1'b0, mix_gain};
    assign ratio_span = $signed({1'b0, max_ratio_reg}) - $signed({1'b0, min_ratio_reg});

    assign ratio_full = round_shift(prod_t'($signed({1'b0, min_ratio_reg, 16'b0})) + prod, 16);
    assign low_sum    = prod_t'(low_state_reg) + round_shift(prod, 14);
    assign high_sum   = prod_t'(x_reg) - prod_t'(low_state_reg) - round_shift(prod, 14);
    assign band_sum   = prod_t'(band_state_reg) + round_shift(prod, 14);
    assign mix_sum    = round_shift(acc_reg + prod, 15);

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_MUL_RATIO:
            begin
                op_a = mul_a_t'(ratio_span);
                op_b = mul_b_t'($signed({1'b0, lfo_val}));
            end
            ST_MUL_LOW:
            begin
                op_a = mul_a_t'(band_state_reg);
                op_b = mul_b_t'($signed({2'b0, coeff_val}));
            end
            ST_LOW:
            begin
                op_a = mul_a_t'(band_state_reg);
                op_b = mul_b_t'($signed({2'b0, damping_reg}));
            end
            ST_MUL_BAND:
            begin
                op_a = high_reg;
                op_b = mul_b_t'($signed({2'b0, coeff_val}));
            end
            ST_BAND:
            begin
                op_a = mul_a_t'(x_reg);
                op_b = mul_b_t'($signed({1'b0, dry_gain}));
            end
            ST_MIX1:
            begin
                op_a = mul_a_t'(band_state_reg);
                op_b = mul_b_t'($signed({2'b0, mix_gain}));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        enabled_next    = enabled_reg;
        phase_step_next = phase_step_reg;
        min_ratio_next  = min_ratio_reg;
        max_ratio_next  = max_ratio_reg;
        damping_next    = damping_reg;
        wet_mix_next    = wet_mix_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ENABLED:    enabled_next    = cfg_wr_data[0];
                REG_PHASE_STEP: phase_step_next = cfg_wr_data[STEP_W-1:0];
                REG_MIN_RATIO:  min_ratio_next  = cfg_wr_data[RATIO_W-1:0];
                REG_MAX_RATIO:  max_ratio_next  = cfg_wr_data[RATIO_W-1:0];
                REG_DAMPING:    damping_next    = cfg_wr_data[GAIN_W-1:0];
                REG_WET_MIX:    wet_mix_next    = cfg_wr_data[GAIN_W-1:0];
                default:        enabled_next    = enabled_reg;
            endcase
        end
    end

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        low_state_next  = low_state_reg;
        band_state_next = band_state_reg;
        lfo_phase_next  = lfo_phase_reg;
        x_next          = x_reg;
        ratio_next      = ratio_reg;
        high_next       = high_reg;
        acc_next        = acc_reg;
        y_next          = y_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_data_next   = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x_next = audio.sample_in;
                    y_next = audio.sample_in;
                    state_next = enabled_reg ? ST_MUL_RATIO : ST_DONE;
                end
            end
            ST_MUL_RATIO:
            begin
                state_next = ST_RATIO;
            end
            ST_RATIO:
            begin
                if (ratio_full > prod_t'($signed({1'b0, RATIO_MAX})))
                begin
                    ratio_next = RATIO_MAX;
                end
                else
                begin
                    ratio_next = ratio_full[CLAMP_W-1:0];
                end
                state_next = ST_COEFF;
            end
            ST_COEFF:
            begin
                state_next = ST_MUL_LOW;
            end
            ST_MUL_LOW:
            begin
                state_next = ST_LOW;
            end
            ST_LOW:
            begin
                low_state_next = sat_state(low_sum);
                state_next     = ST_HIGH;
            end
            ST_HIGH:
            begin
                high_next  = high_sum[MUL_A_W-1:0];
                state_next = ST_MUL_BAND;
            end
            ST_MUL_BAND:
            begin
                state_next = ST_BAND;
            end
            ST_BAND:
            begin
                band_state_next = sat_state(band_sum);
                lfo_phase_next  = lfo_phase_reg + PHASE_W'(phase_step_reg);
                state_next      = ST_MIX1;
            end
            ST_MIX1:
            begin
                acc_next   = prod;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                y_next     = sat_sample(mix_sum);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = y_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            enabled_reg    <= 1'b0;
            phase_step_reg <= '0;
            min_ratio_reg  <= '0;
            max_ratio_reg  <= '0;
            damping_reg    <= DAMPING_RESET;
            wet_mix_reg    <= MIX_ONE;
            low_state_reg  <= '0;
            band_state_reg <= '0;
            lfo_phase_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            enabled_reg    <= enabled_next;
            phase_step_reg <= phase_step_next;
            min_ratio_reg  <= min_ratio_next;
            max_ratio_reg  <= max_ratio_next;
            damping_reg    <= damping_next;
            wet_mix_reg    <= wet_mix_next;
            low_state_reg  <= low_state_next;
            band_state_reg <= band_state_next;
            lfo_phase_reg  <= lfo_phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        ratio_reg    <= ratio_next;
        high_reg     <= high_next;
        acc_reg      <= acc_next;
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
